// ===== sv/sam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sam_pkg;

  // action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // configuration register indexes
  localparam logic CFG_BASE_SIZE = 1'b0;
  localparam logic CFG_INTERLACE = 1'b1;

  localparam int OBJ_COUNT = 128;
  localparam int ROW_W     = 7;   // object row in the low area
  localparam int HI_DEPTH  = 32;
  localparam int HI_ADDR_W = 5;   // byte in the high area
  localparam int LANES     = 4;

  localparam logic [2:0] QUIRK_BASE   = 3'd6;
  localparam logic [6:0] QUIRK_HEIGHT = 7'd16;

  localparam logic [6:0] SMALL_W [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [6:0] LARGE_W [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [6:0] SMALL_H [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_H [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [LANES-1:0] mask;
  } lo_wr_t;

  typedef struct packed {
    logic [6:0] w;
    logic [6:0] h;
  } dims_t;

  function automatic dims_t sprite_dims(input logic is_large, input logic [2:0] bs,
                                        input logic il);
    dims_t d;
    if (is_large) begin
      d.w = LARGE_W[bs];
      d.h = LARGE_H[bs];
    end else begin
      d.w = SMALL_W[bs];
      d.h = (il && bs >= QUIRK_BASE) ? QUIRK_HEIGHT : SMALL_H[bs];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sam_lo_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// per-object bytes: lane 0 x low, 1 y, 2 tile, 3 attributes
module sam_lo_mem import sam_pkg::*; (
  input  wire logic                   clk,
  input  wire lo_wr_t                 wr,
  input  wire logic [LANES-1:0][7:0]  wr_data,
  input  wire logic                   rd_en,
  input  wire logic [ROW_W-1:0]       rd_row,
  output logic      [LANES-1:0][7:0]  rd_data
);

  logic [LANES-1:0][7:0] mem [OBJ_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < LANES; i++) begin
        if (wr.mask[i]) begin
          mem[wr.row][i] <= wr_data[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sam_hi_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// high area: each byte holds {size, x8} pairs of four objects
module sam_hi_mem import sam_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [HI_ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]           wr_data,
  input  wire logic                 rd_en,
  input  wire logic [HI_ADDR_W-1:0] rd_addr,
  output logic      [7:0]           rd_data
);

  logic [7:0] mem [HI_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sprite_attribute_memory.sv =====
`timescale 1ns / 1ps
`default_nettype none

// path: an accepted word passes the memory read register, then the output register
// throughput: one word per cycle unless the output stalls; each memory read port sets this
// reset: a clearing pass zeroes the low memory one row per cycle, all 128 rows, and the
//   high memory during its first 32 rows; no input word is taken until it ends
// configuration writes are taken at any time, cfg_ready is always high
module sprite_attribute_memory import sam_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [2:0] cfg_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] action,
  input  wire logic [9:0] address,
  input  wire logic [7:0] write_data,
  input  wire logic [6:0] object_index,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      read_data,
  output logic [6:0]      sprite_width,
  output logic [6:0]      sprite_height
);

  // configuration registers
  logic [2:0] base_size;
  logic       interlace_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size    <= '0;
      interlace_on <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_SIZE: base_size    <= cfg_data;
        CFG_INTERLACE: interlace_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic             clearing;
  logic [ROW_W-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(OBJ_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // handshake and pipeline control
  logic accept;
  logic pend_valid;
  logic pend_move;

  assign pend_move = !out_valid || !out_stall;
  assign in_stall  = clearing || (pend_valid && !pend_move);
  assign accept    = in_valid && !in_stall;

  // decode of the accepted word
  logic is_hi;
  logic do_write;
  logic do_read;

  assign is_hi    = address[9];
  assign do_write = accept && (action == ACT_WRITE);
  assign do_read  = accept && (action == ACT_READ || action == ACT_QUERY);

  // low memory write port: a byte lane on a cpu write, whole rows while clearing
  lo_wr_t                lo_wr;
  logic [LANES-1:0][7:0] lo_wdata;
  logic [LANES-1:0][7:0] lo_rdata;

  always_comb begin
    lo_wr.en   = clearing || (do_write && !is_hi);
    lo_wr.row  = clearing ? clr_row : address[8:2];
    lo_wr.mask = '0;
    if (clearing) begin
      lo_wr.mask = '1;
    end else begin
      lo_wr.mask[address[1:0]] = 1'b1;
    end
    lo_wdata = clearing ? '0 : {LANES{write_data}};
  end

  sam_lo_mem u_lo_mem (
    .clk     (clk),
    .wr      (lo_wr),
    .wr_data (lo_wdata),
    .rd_en   (do_read),
    .rd_row  (address[8:2]),
    .rd_data (lo_rdata)
  );

  // high memory: cleared while the pass is on its first 32 rows
  logic                 hi_wen;
  logic [HI_ADDR_W-1:0] hi_waddr;
  logic [7:0]           hi_wdata;
  logic [HI_ADDR_W-1:0] hi_raddr;
  logic [7:0]           hi_rdata;

  assign hi_wen   = clearing ? (clr_row[ROW_W-1:HI_ADDR_W] == '0) : (do_write && is_hi);
  assign hi_waddr = clearing ? clr_row[HI_ADDR_W-1:0] : address[HI_ADDR_W-1:0];
  assign hi_wdata = clearing ? 8'd0 : write_data;
  // a query needs the size bit, kept in the byte of its group of four
  assign hi_raddr = (action == ACT_QUERY) ? object_index[6:2] : address[HI_ADDR_W-1:0];

  sam_hi_mem u_hi_mem (
    .clk     (clk),
    .wr_en   (hi_wen),
    .wr_addr (hi_waddr),
    .wr_data (hi_wdata),
    .rd_en   (do_read),
    .rd_addr (hi_raddr),
    .rd_data (hi_rdata)
  );

  // word in flight while the memories deliver read data
  logic [1:0] pend_action;
  logic       pend_hi;
  logic [1:0] pend_lane;
  logic [1:0] pend_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_action <= action;
      pend_hi     <= is_hi;
      pend_lane   <= address[1:0];
      pend_pair   <= object_index[1:0];
    end
  end

  // result formatting
  logic [7:0] res_data;
  dims_t      res_dims;
  logic       size_bit;

  always_comb begin
    size_bit = hi_rdata[{pend_pair, 1'b1}];
    res_data = 8'd0;
    res_dims = '0;
    case (pend_action)
      ACT_READ:  res_data = pend_hi ? hi_rdata : lo_rdata[pend_lane];
      ACT_QUERY: res_dims = sprite_dims(size_bit, base_size, interlace_on);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_valid && pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && pend_move) begin
      read_data     <= res_data;
      sprite_width  <= res_dims.w;
      sprite_height <= res_dims.h;
    end
  end

  // no word is taken while the memories are still being cleared
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !clearing)
    else $error("input word accepted during clearing pass");

  // a result carries either a byte or dimensions, never both
  assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != 8'd0 |-> sprite_width == 7'd0 && sprite_height == 7'd0)
    else $error("result carries byte and dimensions together");

  // the clearing pass covers every row
  assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_row) == ROW_W'(OBJ_COUNT - 1))
    else $error("clearing pass ended early");

  // a held word in flight always stalls the input
  assert property (@(posedge clk) disable iff (rst)
    pend_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while result path is blocked");

endmodule

`default_nettype wire

// ===== dv/sprite_attribute_memory_tb.sv =====
`timescale 1ns / 1ps

module sprite_attribute_memory_tb;
  import sam_pkg::*;

  // action code the block must treat as a no-op
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // byte lanes of an object row in the low area
  localparam logic [1:0] LANE_X    = 2'd0;
  localparam logic [1:0] LANE_Y    = 2'd1;
  localparam logic [1:0] LANE_TILE = 2'd2;
  localparam logic [1:0] LANE_ATTR = 2'd3;

  // sprite dimension tables, indexed by base size
  localparam logic [6:0] SMALL_WIDTH  [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [6:0] LARGE_WIDTH  [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [6:0] SMALL_HEIGHT [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_HEIGHT [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};
  // interlace squashes small sprites at the two largest base sizes
  localparam logic [2:0] INTERLACE_MIN_SIZE = 3'd6;
  localparam logic [6:0] INTERLACE_HEIGHT   = 7'd16;

  // run shape
  localparam int IDLE_LIMIT   = 2000;  // covers the clearing pass and long stalls
  localparam int DRAIN_CYCLES = 4;     // margin for the pipe to settle
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 173;

  // receiver stall styles
  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;
  localparam int STALL_LONG    = 3;

  typedef struct packed {
    logic [1:0] act;
    logic [9:0] addr;
    logic [7:0] wdata;
    logic [6:0] obj;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [6:0] w;
    logic [6:0] h;
  } attr_result_t;

  typedef enum logic [1:0] {STEP_WORD, STEP_SET_SIZE, STEP_SET_INTERLACE} step_kind_e;

  typedef struct packed {
    step_kind_e   kind;
    bus_word_t    word;
    logic         typed;   // want holds a hand-written answer
    attr_result_t want;
    logic [2:0]   val;     // register value for config steps
  } step_t;

  // dut signals
  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [2:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] action;
  logic [9:0] address;
  logic [7:0] write_data;
  logic [6:0] object_index;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic [6:0] sprite_width;
  logic [6:0] sprite_height;

  // shadow copy of the attribute table
  logic [7:0] x_low     [OBJ_COUNT];
  logic       x_msb     [OBJ_COUNT];
  logic [7:0] y_pos     [OBJ_COUNT];
  logic [7:0] tile_num  [OBJ_COUNT];
  logic [7:0] attr_byte [OBJ_COUNT];
  logic       big_size  [OBJ_COUNT];
  logic [2:0] size_sel;
  logic       interlace;

  attr_result_t expected_q [$];
  step_t        plan [$];

  int errors = 0;
  int checked_n = 0;
  int reads_n = 0, writes_n = 0, queries_n = 0, unused_n = 0, cfg_n = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  logic [9:0] last_addr = '0;
  int stuck_cycles = 0;
  int stall_mode = STALL_NONE;
  logic [15:0] stall_pattern = '0;
  logic [7:0] stall_tick = '0;

  sprite_attribute_memory uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .address(address),
    .write_data(write_data),
    .object_index(object_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .sprite_width(sprite_width),
    .sprite_height(sprite_height)
  );

  always #5 clk = ~clk;

  // apply one bus word to the shadow table and return what the block should answer
  function automatic attr_result_t access_table(input bus_word_t w);
    attr_result_t r;
    logic [6:0] row;
    logic [6:0] o;
    int k;
    r = '0;
    row = w.addr[8:2];
    case (w.act)
      ACT_READ: begin
        if (!w.addr[9]) begin
          case (w.addr[1:0])
            LANE_X:    r.rd = x_low[row];
            LANE_Y:    r.rd = y_pos[row];
            LANE_TILE: r.rd = tile_num[row];
            default:   r.rd = attr_byte[row];
          endcase
        end else begin
          // high area wraps every 32 bytes, four {size, x msb} pairs per byte
          for (k = 0; k < 4; k++) begin
            o = {w.addr[4:0], k[1:0]};
            r.rd[2*k]   = x_msb[o];
            r.rd[2*k+1] = big_size[o];
          end
        end
      end
      ACT_WRITE: begin
        if (!w.addr[9]) begin
          case (w.addr[1:0])
            LANE_X:    x_low[row] = w.wdata;
            LANE_Y:    y_pos[row] = w.wdata;
            LANE_TILE: tile_num[row] = w.wdata;
            default:   attr_byte[row] = w.wdata;
          endcase
        end else begin
          for (k = 0; k < 4; k++) begin
            o = {w.addr[4:0], k[1:0]};
            x_msb[o]    = w.wdata[2*k];
            big_size[o] = w.wdata[2*k+1];
          end
        end
      end
      ACT_QUERY: begin
        if (big_size[w.obj]) begin
          r.w = LARGE_WIDTH[size_sel];
          r.h = LARGE_HEIGHT[size_sel];
        end else begin
          r.w = SMALL_WIDTH[size_sel];
          r.h = (interlace && size_sel >= INTERLACE_MIN_SIZE) ? INTERLACE_HEIGHT
                                                               : SMALL_HEIGHT[size_sel];
        end
      end
      default: ;  // unused code leaves the table alone and answers zero
    endcase
    return r;
  endfunction

  // random traffic with some address locality so writes are read back
  function automatic bus_word_t random_word();
    bus_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) w.act = ACT_WRITE;
    else if (pick < 76) w.act = ACT_READ;
    else if (pick < 95) w.act = ACT_QUERY;
    else w.act = ACT_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 35) w.addr = last_addr ^ 10'($urandom_range(0, 3));
    else if (pick < 60) w.addr = {1'b1, 9'($urandom)};
    else w.addr = 10'($urandom);
    w.wdata = 8'($urandom);
    // queries lean toward the objects whose size bits were just touched
    if ($urandom_range(0, 2) == 0) w.obj = {last_addr[4:0], 2'($urandom)};
    else w.obj = 7'($urandom);
    last_addr = w.addr;
    return w;
  endfunction

  function automatic void add_word(input logic [1:0] act, input logic [9:0] addr,
                                   input logic [7:0] wdata, input logic [6:0] obj,
                                   input logic typed, input logic [7:0] rd,
                                   input logic [6:0] w, input logic [6:0] h);
    step_t s;
    s = '0;
    s.kind = STEP_WORD;
    s.word = '{act, addr, wdata, obj};
    s.typed = typed;
    s.want = '{rd, w, h};
    plan.push_back(s);
  endfunction

  function automatic void add_cfg(input step_kind_e kind, input logic [2:0] val);
    step_t s;
    s = '0;
    s.kind = kind;
    s.val = val;
    plan.push_back(s);
  endfunction

  // sender: bursts of random length, random gaps between bursts when enabled
  task automatic send_word(input bus_word_t w, input logic typed, input attr_result_t want);
    attr_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    action       <= w.act;
    address      <= w.addr;
    write_data   <= w.wdata;
    object_index <= w.obj;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = access_table(w);
    expected_q.push_back(typed ? want : predicted);
    case (w.act)
      ACT_READ:  reads_n++;
      ACT_WRITE: writes_n++;
      ACT_QUERY: queries_n++;
      default:   unused_n++;
    endcase
  endtask

  // stop sending and wait for every pending result, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic which, input logic [2:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (which == CFG_BASE_SIZE) size_sel = val;
    else interlace = val[0];
    cfg_n++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stall: style and pattern change each time stall_tick wraps to zero
  always @(negedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick == 8'd0) begin
      stall_pattern <= 16'($urandom);
      stall_mode <= $urandom_range(STALL_NONE, STALL_LONG);
    end
    case (stall_mode)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
      STALL_PATTERN: out_stall <= stall_pattern[stall_tick[3:0]];
      default:       out_stall <= (stall_tick[5:0] >= 6'd52);  // stalled for tick values 52 to 63 of each 64
    endcase
  end

  // result checker: each word out is matched against the oldest expectation
  always @(posedge clk) begin : check_results
    attr_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      checked_n++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, actual rd=%02h w=%0d h=%0d", $time,
                 read_data, sprite_width, sprite_height);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (read_data !== want.rd) begin
          $display("%0t: read_data expected %02h actual %02h", $time, want.rd, read_data);
          errors++;
        end
        if (sprite_width !== want.w) begin
          $display("%0t: sprite_width expected %0d actual %0d", $time, want.w, sprite_width);
          errors++;
        end
        if (sprite_height !== want.h) begin
          $display("%0t: sprite_height expected %0d actual %0d", $time, want.h,
                   sprite_height);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles where no handshake completes anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results pending", $time,
               IDLE_LIMIT, expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    step_t s;
    int p;
    int i;
    int k;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    action       = ACT_READ;
    address      = '0;
    write_data   = '0;
    object_index = '0;
    // shadow table and registers start cleared, as after reset
    for (k = 0; k < OBJ_COUNT; k++) begin
      x_low[k] = '0;
      x_msb[k] = 1'b0;
      y_pos[k] = '0;
      tile_num[k] = '0;
      attr_byte[k] = '0;
      big_size[k] = 1'b0;
    end
    size_sel  = '0;
    interlace = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part; the clearing pass shows up as in_stall on the first word
    add_word(ACT_READ,   10'h000, 8'h00, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);   // cleared low byte
    add_word(ACT_READ,   10'h3ff, 8'h00, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);   // cleared high byte
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd0,   1'b1, 8'h00, 7'd8,  7'd8);   // small at size 0
    add_word(ACT_WRITE,  10'h000, 8'hff, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);   // object 0 x low
    add_word(ACT_WRITE,  10'h1ff, 8'ha5, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);   // last attr byte
    add_word(ACT_READ,   10'h1ff, 8'h00, 7'd0,   1'b1, 8'ha5, 7'd0,  7'd0);
    add_word(ACT_WRITE,  10'h200, 8'hff, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);   // objects 0-3 large
    add_word(ACT_READ,   10'h000, 8'h00, 7'd0,   1'b1, 8'hff, 7'd0,  7'd0);   // x low kept
    add_word(ACT_READ,   10'h220, 8'h00, 7'd0,   1'b1, 8'hff, 7'd0,  7'd0);   // high area alias
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd127, 1'b1, 8'h00, 7'd8,  7'd8);
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd3,   1'b1, 8'h00, 7'd16, 7'd16);  // large at size 0
    add_word(ACT_UNUSED, 10'h000, 8'h00, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);
    add_word(ACT_WRITE,  10'h3ff, 8'h80, 7'd0,   1'b1, 8'h00, 7'd0,  7'd0);   // object 127 large
    add_cfg(STEP_SET_SIZE, 3'd7);
    add_cfg(STEP_SET_INTERLACE, 3'd1);
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd0,   1'b1, 8'h00, 7'd32, 7'd32);
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd5,   1'b1, 8'h00, 7'd16, 7'd16);  // interlace squash
    add_cfg(STEP_SET_SIZE, 3'd6);
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd5,   1'b1, 8'h00, 7'd16, 7'd16);
    add_cfg(STEP_SET_INTERLACE, 3'd0);
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd5,   1'b1, 8'h00, 7'd16, 7'd32);
    add_word(ACT_QUERY,  10'h000, 8'h00, 7'd127, 1'b1, 8'h00, 7'd32, 7'd64);
    add_word(ACT_WRITE,  10'h002, 8'h3c, 7'd0,   1'b0, 8'h00, 7'd0,  7'd0);
    add_word(ACT_READ,   10'h002, 8'h00, 7'd0,   1'b0, 8'h00, 7'd0,  7'd0);
    add_word(ACT_UNUSED, 10'h3ff, 8'hff, 7'd127, 1'b1, 8'h00, 7'd0,  7'd0);   // all ones, no-op
    add_word(ACT_READ,   10'h3e0, 8'h00, 7'd0,   1'b0, 8'h00, 7'd0,  7'd0);

    foreach (plan[i]) begin
      s = plan[i];
      case (s.kind)
        STEP_WORD: send_word(s.word, s.typed, s.want);
        STEP_SET_SIZE: begin
          drain();
          write_config(CFG_BASE_SIZE, s.val);
        end
        default: begin
          drain();
          write_config(CFG_INTERLACE, s.val);
        end
      endcase
    end

    // random phases, each under its own register setting; extremes come first
    for (p = 0; p < PHASES; p++) begin
      drain();
      gaps_on = (p % 3 != 2);
      case (p)
        0: write_config(CFG_BASE_SIZE, 3'd0);
        1: write_config(CFG_BASE_SIZE, 3'd7);
        2, 3: write_config(CFG_BASE_SIZE, 3'd6);
        default: write_config(CFG_BASE_SIZE, 3'($urandom_range(0, 7)));
      endcase
      write_config(CFG_INTERLACE, {2'b00, p[0]});
      for (i = 0; i < PHASE_WORDS; i++) send_word(random_word(), 1'b0, '0);
    end
    drain();

    $display("covered %0d reads, %0d writes, %0d dimension queries, %0d unused-code words",
             reads_n, writes_n, queries_n, unused_n);
    $display("%0d register writes, %0d result words checked, %0d mismatches",
             cfg_n, checked_n, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
